### hdl/segment_lcd_serial_writer_unit_defines.svh
// Assertion macros for the segment LCD serial writer.
// Used by the checker file; depends on nothing else.
`ifndef SEGMENT_LCD_SERIAL_WRITER_UNIT_DEFINES_SVH
`define SEGMENT_LCD_SERIAL_WRITER_UNIT_DEFINES_SVH

// same-cycle implication
`define SLCD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SLCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/slcd_pkg.sv
// Shared types, constants and helpers for the segment LCD serial writer.
// Used by every module of the block; depends on nothing.
package slcd_pkg;

   localparam int SEG_ADDRS   = 32;
   localparam int ADDR_W      = (SEG_ADDRS > 1) ? $clog2(SEG_ADDRS) : 1;
   localparam int LEFT_W      = $clog2(SEG_ADDRS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  CMD_HEAD          = 8'h80;
   localparam logic [7:0]  WRITE_HEAD        = 8'hA0;
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd200;

   localparam logic [4:0] CMD_BITS    = 5'd12;
   localparam logic [4:0] ADDR_BITS   = 5'd9;
   localparam logic [4:0] NIBBLE_BITS = 5'd4;

   localparam logic [1:0] OP_COMMAND = 2'd0;
   localparam logic [1:0] OP_SET     = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_WIPE    = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] command;
      logic [4:0] seg_addr;
      logic [3:0] com_bits;
   } req_type;

   typedef struct packed {
      logic [15:0] frame_bits;
      logic [4:0]  bit_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] cmd;
      logic [5:0] addr;
      logic [3:0] nibble;
   } job_type;

   function automatic logic [ADDR_W-1:0] wrap_seg_addr(input logic [4:0] a);
      logic [ADDR_W-1:0] r;
      r = '0;
      for (int k = 0; k < 32; k++) begin
         if (a == 5'(k)) r = ADDR_W'(k % SEG_ADDRS);
      end
      return r;
   endfunction

   function automatic logic [3:0] reverse_nibble(input logic [3:0] n);
      return {n[0], n[1], n[2], n[3]};
   endfunction

endpackage

### hdl/slcd_front.sv
// Front end: accepts requests, keeps the shadow nibble store, forms frame jobs.
// Depends on slcd_pkg.
module slcd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  slcd_pkg::req_type req_payload,
   output logic             job_valid,
   input  logic             job_ready,
   output slcd_pkg::job_type job_data
);
   import slcd_pkg::*;

   logic [3:0]        shadow_ff [SEG_ADDRS];
   logic [ADDR_W-1:0] wrap_addr;
   logic [3:0]        old_nib;
   logic [3:0]        new_nib;
   logic              accept;

   always_comb begin
      wrap_addr = wrap_seg_addr(req_payload.seg_addr);
      old_nib   = shadow_ff[wrap_addr];
      if (req_payload.operation == OP_SET) begin
         new_nib = old_nib | req_payload.com_bits;
      end else begin
         new_nib = old_nib & ~req_payload.com_bits;
      end
      req_ready       = job_ready;
      job_valid       = req_valid;
      accept          = req_valid && job_ready;
      job_data.op     = req_payload.operation;
      job_data.cmd    = req_payload.command;
      job_data.addr   = (req_payload.operation == OP_WIPE) ? 6'd0 : 6'(wrap_addr);
      job_data.nibble = new_nib;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEG_ADDRS; i++) shadow_ff[i] <= '0;
      end else if (accept) begin
         unique case (req_payload.operation) inside
            OP_SET, OP_CLEAR: begin
               shadow_ff[wrap_addr] <= new_nib;
            end
            OP_WIPE: begin
               for (int i = 0; i < SEG_ADDRS; i++) shadow_ff[i] <= '0;
            end
            default: ;
         endcase
      end
   end

endmodule

### hdl/slcd_job_fifo.sv
// Short job queue between the front end and the serial back end.
// Depends on slcd_pkg.
module slcd_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  slcd_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output slcd_pkg::job_type pop_data
);
   import slcd_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   always_comb begin
      push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_data   = mem_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### hdl/slcd_back.sv
// Back end: times each bit group on the write strobe and hands groups out as beats.
// Depends on slcd_pkg.
module slcd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       half_period,
   input  logic              job_valid,
   output logic              job_ready,
   input  slcd_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slcd_pkg::rsp_type rsp_payload
);
   import slcd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEND = 2'd1;
   localparam logic [1:0] ST_PUT  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [15:0]       timer_ff, timer_in;
   logic              phase_ff, phase_in;
   logic [4:0]        bits_left_ff, bits_left_in;
   logic [LEFT_W-1:0] grp_left_ff, grp_left_in;
   logic              wipe_ff, wipe_in;
   logic [3:0]        nibble_ff, nibble_in;
   rsp_type           grp_ff, grp_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              out_free;

   always_comb begin
      state_in     = state_ff;
      timer_in     = timer_ff;
      phase_in     = phase_ff;
      bits_left_in = bits_left_ff;
      grp_left_in  = grp_left_ff;
      wipe_in      = wipe_ff;
      nibble_in    = nibble_ff;
      grp_in       = grp_ff;
      out_in       = out_ff;
      out_free     = !out_valid_ff || rsp_ready;
      out_valid_in = out_valid_ff && !rsp_ready;
      job_ready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               wipe_in   = (job_data.op == OP_WIPE);
               nibble_in = job_data.nibble;
               if (job_data.op == OP_COMMAND) begin
                  grp_in.frame_bits = 16'({CMD_HEAD[7:4], job_data.cmd});
                  grp_in.bit_count  = CMD_BITS;
                  grp_in.last       = 1'b1;
                  grp_left_in       = '0;
               end else begin
                  grp_in.frame_bits = 16'({WRITE_HEAD[7:5], job_data.addr});
                  grp_in.bit_count  = ADDR_BITS;
                  grp_in.last       = 1'b0;
                  grp_left_in       = (job_data.op == OP_WIPE) ? LEFT_W'(SEG_ADDRS)
                                                               : LEFT_W'(1);
               end
               bits_left_in = grp_in.bit_count;
               timer_in     = half_period;
               phase_in     = 1'b0;
               state_in     = ST_SEND;
            end
         end
         ST_SEND: begin
            if (timer_ff > 16'd1) begin
               timer_in = timer_ff - 16'd1;
            end else begin
               timer_in = half_period;
               phase_in = ~phase_ff;
               if (phase_ff) begin
                  if (bits_left_ff == 5'd1) begin
                     state_in = ST_PUT;
                  end else begin
                     bits_left_in = bits_left_ff - 5'd1;
                  end
               end
            end
         end
         ST_PUT: begin
            if (out_free) begin
               out_in       = grp_ff;
               out_valid_in = 1'b1;
               if (grp_left_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  grp_in.frame_bits = wipe_ff ? 16'd0 : 16'(reverse_nibble(nibble_ff));
                  grp_in.bit_count  = NIBBLE_BITS;
                  grp_in.last       = (grp_left_ff == LEFT_W'(1));
                  grp_left_in       = grp_left_ff - 1'b1;
                  bits_left_in      = NIBBLE_BITS;
                  timer_in          = half_period;
                  phase_in          = 1'b0;
                  state_in          = ST_SEND;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         timer_ff     <= '0;
         phase_ff     <= 1'b0;
         bits_left_ff <= '0;
         grp_left_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         timer_ff     <= timer_in;
         phase_ff     <= phase_in;
         bits_left_ff <= bits_left_in;
         grp_left_ff  <= grp_left_in;
      end
   end

   always_ff @(posedge clock) begin
      wipe_ff   <= wipe_in;
      nibble_ff <= nibble_in;
      grp_ff    <= grp_in;
      out_ff    <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

### hdl/segment_lcd_serial_writer_unit.sv
// Segment LCD serial writer: request front end, job queue and strobe-timed back end.
// Depends on slcd_pkg, slcd_front, slcd_job_fifo and slcd_back.
//
// Each request becomes one chip-select frame of bit groups, and each group leaves
// as one rsp beat after its bits have been clocked out on the write strobe timer,
// each bit being two strobe phases timed by half_period (0 counts as 1; resets to 200).
// A command frame is 12 bits, a set or clear frame 13 bits in two groups, and a
// screen clear 9 + 4 * SEG_ADDRS bits in 1 + SEG_ADDRS groups. The back end serves
// one frame at a time, while the front end updates the shadow store and queues up
// to two more requests. The shadow store resets to zero at once.
module segment_lcd_serial_writer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  slcd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slcd_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   import slcd_pkg::*;

   logic [15:0] half_period_ff;
   logic        fj_valid, fj_ready;
   job_type     fj_data;
   logic        bj_valid, bj_ready;
   job_type     bj_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_wr_en) begin
         half_period_ff <= csr_wr_data;
      end
   end

   slcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .job_valid   (fj_valid),
      .job_ready   (fj_ready),
      .job_data    (fj_data)
   );

   slcd_job_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_ready (fj_ready),
      .push_data  (fj_data),
      .pop_valid  (bj_valid),
      .pop_ready  (bj_ready),
      .pop_data   (bj_data)
   );

   slcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_period_ff),
      .job_valid   (bj_valid),
      .job_ready   (bj_ready),
      .job_data    (bj_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/slcd_checker.sv
// Port-level checks on the result beats of the segment LCD serial writer.
// Depends on slcd_pkg and the assertion macro header; bound to the top level.
`include "segment_lcd_serial_writer_unit_defines.svh"

module slcd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input slcd_pkg::rsp_type rsp_payload
);
   import slcd_pkg::*;

   `SLCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `SLCD_ASSERT_IMPLY(a_count_legal, clock, reset, rsp_valid, rsp_payload.bit_count == 5'd4 || rsp_payload.bit_count == 5'd9 || rsp_payload.bit_count == 5'd12)
   `SLCD_ASSERT_IMPLY(a_nibble_clean, clock, reset, rsp_valid && rsp_payload.bit_count == 5'd4, rsp_payload.frame_bits[15:4] == 12'd0)
   `SLCD_ASSERT_IMPLY(a_cmd_frame, clock, reset, rsp_valid && rsp_payload.bit_count == 5'd12, rsp_payload.last && rsp_payload.frame_bits[15:8] == 8'h08)
   `SLCD_ASSERT_IMPLY(a_addr_group, clock, reset, rsp_valid && rsp_payload.bit_count == 5'd9, !rsp_payload.last && rsp_payload.frame_bits[15:6] == 10'b0000000101)

endmodule

bind segment_lcd_serial_writer_unit slcd_checker u_slcd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### tb/sv/tb_segment_lcd_serial_writer_unit.sv
// Self-checking testbench for segment_lcd_serial_writer_unit: a directed table, then random
// frames under several strobe settings and idle patterns; each beat is checked against
// the table's groups or a shadow-store predictor. Depends on slcd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_segment_lcd_serial_writer_unit;
   import slcd_pkg::*;

   typedef struct {
      req_type req;
      int      typed;
      rsp_type grp0;
      rsp_type grp1;
   } lcd_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   rsp_type     lcd_groups_due[$];
   logic [3:0]  shadow_nib [SEG_ADDRS];
   int          errors = 0;
   int          sender_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          strobe_half = 200;
   bit          strobe_used = 1'b0;

   logic [15:0] phase_half [4] = '{16'd1, 16'd2, 16'd3, 16'd1};
   int          phase_idle [4] = '{0, 84, 0, 38};
   int          phase_stall [4] = '{0, 0, 84, 38};

   lcd_row_type script [18] = '{
      '{'{OP_COMMAND, 8'h00, 5'd0,  4'h0}, 1, '{16'h0800, CMD_BITS, 1'b1}, '0},
      '{'{OP_COMMAND, 8'hFF, 5'd31, 4'hF}, 1, '{16'h08FF, CMD_BITS, 1'b1}, '0},
      '{'{OP_SET,     8'h00, 5'd31, 4'hF}, 2, '{16'h015F, ADDR_BITS, 1'b0},
                                              '{16'h000F, NIBBLE_BITS, 1'b1}},
      '{'{OP_SET,     8'hFF, 5'd0,  4'h1}, 2, '{16'h0140, ADDR_BITS, 1'b0},
                                              '{16'h0008, NIBBLE_BITS, 1'b1}},
      '{'{OP_SET,     8'h00, 5'd0,  4'h2}, 0, '0, '0},
      '{'{OP_CLEAR,   8'h00, 5'd0,  4'h1}, 0, '0, '0},
      '{'{OP_CLEAR,   8'h00, 5'd31, 4'h0}, 0, '0, '0},
      '{'{OP_SET,     8'h00, 5'd16, 4'h0}, 0, '0, '0},
      '{'{OP_WIPE,    8'hAA, 5'd5,  4'hF}, 0, '0, '0},
      '{'{OP_SET,     8'h00, 5'd31, 4'h8}, 0, '0, '0},
      '{'{OP_CLEAR,   8'h00, 5'd31, 4'hF}, 0, '0, '0},
      '{'{OP_COMMAND, 8'h55, 5'd31, 4'hF}, 0, '0, '0},
      '{'{OP_COMMAND, 8'hAA, 5'd10, 4'h5}, 0, '0, '0},
      '{'{OP_SET,     8'h12, 5'd10, 4'h5}, 0, '0, '0},
      '{'{OP_SET,     8'h34, 5'd21, 4'hA}, 0, '0, '0},
      '{'{OP_CLEAR,   8'h56, 5'd10, 4'h4}, 0, '0, '0},
      '{'{OP_WIPE,    8'h00, 5'd0,  4'h0}, 0, '0, '0},
      '{'{OP_CLEAR,   8'hFF, 5'd21, 4'hF}, 0, '0, '0}
   };

   segment_lcd_serial_writer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      for (int a = 0; a < SEG_ADDRS; a++) shadow_nib[a] = 4'h0;
   end

   function automatic rsp_type make_group(input logic [15:0] bits, input logic [4:0] count,
                                          input logic is_last);
      rsp_type g;
      g.frame_bits = bits;
      g.bit_count  = count;
      g.last       = is_last;
      return g;
   endfunction

   // update the shadow store and, if emit is set, queue the bit groups one frame produces
   task automatic predict_frame(input req_type r, input bit emit);
      rsp_type    grp [$];
      logic [4:0] slot;
      logic [3:0] nib;
      logic [3:0] sent;
      slot = 5'(r.seg_addr % SEG_ADDRS);
      case (r.operation)
         OP_COMMAND: begin
            grp.push_back(make_group({4'b0, CMD_HEAD[7:4], r.command}, CMD_BITS, 1'b1));
         end
         OP_SET, OP_CLEAR: begin
            nib = shadow_nib[slot];
            if (r.operation == OP_SET) nib = nib | r.com_bits;
            else nib = nib & ~r.com_bits;
            shadow_nib[slot] = nib;
            for (int b = 0; b < 4; b++) sent[3 - b] = nib[b];
            grp.push_back(make_group({7'b0, WRITE_HEAD[7:5], 6'(slot)}, ADDR_BITS, 1'b0));
            grp.push_back(make_group({12'b0, sent}, NIBBLE_BITS, 1'b1));
         end
         OP_WIPE: begin
            grp.push_back(make_group({7'b0, WRITE_HEAD[7:5], 6'b0}, ADDR_BITS, 1'b0));
            for (int k = 0; k < SEG_ADDRS; k++) begin
               shadow_nib[k] = 4'h0;
               grp.push_back(make_group(16'h0000, NIBBLE_BITS, k == SEG_ADDRS - 1));
            end
         end
      endcase
      if (emit) begin
         foreach (grp[i]) lcd_groups_due.push_back(grp[i]);
      end
   endtask

   task automatic send_frame(input req_type r, input int typed, input rsp_type g0,
                             input rsp_type g1, input bit drain_first);
      if (drain_first) begin
         while (lcd_groups_due.size() != 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predict_frame(r, typed == 0);
      if (typed > 0) lcd_groups_due.push_back(g0);
      if (typed > 1) lcd_groups_due.push_back(g1);
      strobe_used = 1'b1;
   endtask

   // drain, let chip select settle, then write the strobe half period
   task automatic set_strobe(input logic [15:0] hp);
      req_valid <= 1'b0;
      while (lcd_groups_due.size() != 0) @(posedge clock);
      if (strobe_used) repeat (2 * strobe_half + 16) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= hp;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      strobe_half = int'(hp);
      strobe_used = 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lcd_groups_due.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual %h", $time, rsp_payload);
            errors++;
         end else begin
            due = lcd_groups_due.pop_front();
            if (rsp_payload.frame_bits !== due.frame_bits) begin
               $display("%0t frame_bits: expected %h, actual %h", $time,
                        due.frame_bits, rsp_payload.frame_bits);
               errors++;
            end
            if (rsp_payload.bit_count !== due.bit_count) begin
               $display("%0t bit_count: expected %0d, actual %0d", $time,
                        due.bit_count, rsp_payload.bit_count);
               errors++;
            end
            if (rsp_payload.last !== due.last) begin
               $display("%0t last: expected %b, actual %b", $time, due.last, rsp_payload.last);
               errors++;
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("tb_segment_lcd_serial_writer_unit NOT OK");
      $finish;
   end

   initial begin
      req_type pick_req;
      int      pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(script); i++) begin
         if (i == 4) set_strobe(16'd0);
         send_frame(script[i].req, script[i].typed, script[i].grp0, script[i].grp1, 1'b0);
      end

      set_strobe(16'hFFFF);
      for (int p = 0; p < 4; p++) begin
         set_strobe(phase_half[p]);
         sender_idle_pct = phase_idle[p];
         recv_stall_pct  = phase_stall[p];
         for (int k = 0; k < 23; k++) begin
            pick = $urandom_range(7);
            pick_req.operation = (pick < 2) ? OP_COMMAND :
                                 (pick < 5) ? OP_SET :
                                 (pick < 7) ? OP_CLEAR : OP_WIPE;
            pick_req.command  = 8'($urandom);
            pick_req.seg_addr = $urandom_range(1) ? 5'($urandom) : 5'($urandom_range(2));
            pick_req.com_bits = 4'($urandom);
            send_frame(pick_req, 0, '0, '0, (k == 14) || ($urandom_range(15) == 0));
         end
      end

      req_valid <= 1'b0;
      while (lcd_groups_due.size() != 0) @(posedge clock);
      repeat (2 * strobe_half + 64) @(posedge clock);
      if (errors == 0) begin
         $display("tb_segment_lcd_serial_writer_unit OK");
      end else begin
         $display("tb_segment_lcd_serial_writer_unit NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/slcd_pkg.sv
hdl/slcd_front.sv
hdl/slcd_job_fifo.sv
hdl/slcd_back.sv
hdl/segment_lcd_serial_writer_unit.sv
hdl/slcd_checker.sv
tb/sv/tb_segment_lcd_serial_writer_unit.sv
